/* rtl/tpq_pkg.sv */
// Shared types, constants and rank compare for the task priority queue.
`default_nettype none

package tpq_pkg;

   // Queue depth, the count width derived from it, and the field widths
   localparam int DEPTH   = 64;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int ID_W    = 15;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 16;

   // Request codes
   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] time_;
   } entry_type;

   typedef struct packed {
      logic insert_en;
      logic extract_en;
   } cell_ctrl_type;

   // True when task n ranks ahead of stored entry e
   function automatic logic ranks_ahead(input entry_type n, input entry_type e);
      logic result;
      if (n.prio != e.prio) begin
         result = n.prio > e.prio;
      end else if (n.time_ != e.time_) begin
         result = n.time_ < e.time_;
      end else begin
         result = n.id < e.id;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* rtl/tpq_cell.sv */
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
`default_nettype none

module tpq_cell
   import tpq_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          occupied,
   input  wire entry_type     new_entry,
   input  wire entry_type     left_entry,
   input  wire logic          left_ahead,
   input  wire entry_type     right_entry,
   output entry_type          entry,
   output logic               ahead
);

   entry_type entry_ff;
   entry_type entry_in;

   // The new task goes at or before this slot when the slot is free or beaten
   assign ahead = !occupied || ranks_ahead(new_entry, entry_ff);
   assign entry = entry_ff;

   // Select the next content: shift right on insert, shift left on extract
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (left_ahead) begin
            entry_in = left_entry;
         end else if (ahead) begin
            entry_in = new_entry;
         end
      end else if (ctrl.extract_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

/* rtl/task_priority_queue.sv */
// Top level of the task priority queue: a sorted chain of slots.
//
// Usage: the req_ channel carries one request per item. req_type selects
// insert (task fields are placed in rank order) or extract (the head task
// is removed and returned). Every request gives exactly one rsp_ item with
// the extracted task (rsp_out_valid high) or zeros, a status and the
// occupancy after the request.
// rsp_valid rises in the cycle after acceptance. One item is taken per
// cycle unless the receiver stalls: each slot compares the new task with
// its entry at once; slots shift by one (on insert, from its place on).
// Capacity is DEPTH tasks; an insert into a full queue is dropped with
// status full, an extract on an empty queue returns status empty.
// Reset empties the queue; slot contents are not cleared, only the count.
// When the receiver stalls, the result holds in the output register and
// req_ready drops until it is taken; a new item is accepted in the same
// cycle that the waiting result is taken.
`default_nettype none

module task_priority_queue
   import tpq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_type,
   input  wire logic [ID_W-1:0]   req_task_id,
   input  wire logic [PRIO_W-1:0] req_task_priority,
   input  wire logic [TIME_W-1:0] req_task_time,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_out_valid,
   output logic [ID_W-1:0]        rsp_out_id,
   output logic [PRIO_W-1:0]      rsp_out_priority,
   output logic [TIME_W-1:0]      rsp_out_time,
   output logic [1:0]             rsp_status,
   output logic [COUNT_W-1:0]     rsp_occupancy
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_valid_ff, out_valid_in;
   entry_type          out_entry_ff, out_entry_in;
   logic [1:0]         status_ff, status_in;

   logic          accept;
   logic          is_full, is_empty;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     cell_entry [DEPTH];
   logic          cell_ahead [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = count_ff == COUNT_W'(DEPTH);
   assign is_empty  = count_ff == '0;

   assign new_entry.id    = req_task_id;
   assign new_entry.prio  = req_task_priority;
   assign new_entry.time_ = req_task_time;

   // Decode the request into shift controls for the chain
   always_comb begin
      ctrl.insert_en  = accept && (req_type == REQ_INSERT) && !is_full;
      ctrl.extract_en = accept && (req_type == REQ_EXTRACT) && !is_empty;
   end

   // Build the chain of slots
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_ahead;
      logic      occupied;

      assign occupied = count_ff > COUNT_W'(i);

      if (i == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_ahead = 1'b0;
      end else begin : g_mid
         assign left_entry = cell_entry[i-1];
         assign left_ahead = cell_ahead[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      tpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_ahead  (left_ahead),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .ahead       (cell_ahead[i])
      );
   end

   // Update the count and form the result item
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_valid_in = out_valid_ff;
      out_entry_in = out_entry_ff;
      status_in    = status_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_valid_in = 1'b0;
         out_entry_in = '0;
         status_in    = STATUS_OK;
         if (req_type == REQ_INSERT) begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               out_valid_in = 1'b1;
               out_entry_in = cell_entry[0];
               count_in     = count_ff - COUNT_W'(1);
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers; occupancy is read from the live count
   always_ff @(posedge clock) begin
      out_valid_ff <= out_valid_in;
      out_entry_ff <= out_entry_in;
      status_ff    <= status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_id       = out_entry_ff.id;
   assign rsp_out_priority = out_entry_ff.prio;
   assign rsp_out_time     = out_entry_ff.time_;
   assign rsp_status       = status_ff;
   assign rsp_occupancy    = count_ff;

endmodule

`default_nettype wire

/* tb/sv/tpq_result_check.sv */
// Checker for the task priority queue: keeps a sorted task list and checks every result item.
`default_nettype none

module tpq_result_check
   import tpq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic              req_type,
   input  wire logic [ID_W-1:0]   req_task_id,
   input  wire logic [PRIO_W-1:0] req_task_priority,
   input  wire logic [TIME_W-1:0] req_task_time,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic              rsp_out_valid,
   input  wire logic [ID_W-1:0]   rsp_out_id,
   input  wire logic [PRIO_W-1:0] rsp_out_priority,
   input  wire logic [TIME_W-1:0] rsp_out_time,
   input  wire logic [1:0]        rsp_status,
   input  wire logic [COUNT_W-1:0] rsp_occupancy,
   output int                     mismatch_count,
   output int                     results_owed
);

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] run_time;
   } queued_task_type;

   typedef struct packed {
      logic                 out_valid;
      queued_task_type      job;
      logic [1:0]           status;
      logic [COUNT_W-1:0]   occupancy;
   } queue_result_type;

   // Tasks in rank order, head first
   queued_task_type  ranked_tasks[$];
   // Results still owed by the block, oldest first
   queue_result_type owed_results[$];

   initial begin
      mismatch_count = 0;
      results_owed   = 0;
   end

   // Higher key ranks ahead: priority up, then time down, then id down
   function automatic logic [PRIO_W+TIME_W+ID_W-1:0] rank_key(input queued_task_type t);
      return {t.prio, ~t.run_time, ~t.id};
   endfunction

   // Apply one request to the task list and return the result it causes
   function automatic queue_result_type apply_request(input logic kind,
                                                      input queued_task_type t);
      queue_result_type r;
      int               slot;
      r = '0;
      if (kind == REQ_INSERT) begin
         if (ranked_tasks.size() >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // find the first stored task that the new one beats
            slot = ranked_tasks.size();
            for (int k = ranked_tasks.size() - 1; k >= 0; k--) begin
               if (rank_key(t) > rank_key(ranked_tasks[k])) begin
                  slot = k;
               end
            end
            ranked_tasks.insert(slot, t);
         end
      end else begin
         if (ranked_tasks.size() == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.out_valid = 1'b1;
            r.job       = ranked_tasks.pop_front();
         end
      end
      r.occupancy = COUNT_W'(ranked_tasks.size());
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: result mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Predict on each accepted request, compare each accepted result
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         ranked_tasks.delete();
         owed_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            owed_results.push_back(apply_request(req_type,
               '{id: req_task_id, prio: req_task_priority, run_time: req_task_time}));
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected item", 64'({rsp_status, rsp_occupancy}), '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_out_valid !== want.out_valid)
                  report_mismatch("out_valid", 64'(rsp_out_valid), 64'(want.out_valid));
               if (rsp_out_id !== want.job.id)
                  report_mismatch("out_id", 64'(rsp_out_id), 64'(want.job.id));
               if (rsp_out_priority !== want.job.prio)
                  report_mismatch("out_priority", 64'(rsp_out_priority),
                                  64'(want.job.prio));
               if (rsp_out_time !== want.job.run_time)
                  report_mismatch("out_time", 64'(rsp_out_time), 64'(want.job.run_time));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch("occupancy", 64'(rsp_occupancy), 64'(want.occupancy));
            end
         end
      end
      results_owed = owed_results.size();
   end

endmodule

`default_nettype wire

/* tb/sv/task_priority_queue_tb.sv */
// Testbench top for the task priority queue: clock, reset, request and result traffic, verdict.
`default_nettype none

module task_priority_queue_tb;
   import tpq_pkg::*;

   localparam int LONG_HOLD   = 200;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_type          = REQ_INSERT;
   logic [ID_W-1:0]    req_task_id       = '0;
   logic [PRIO_W-1:0]  req_task_priority = '0;
   logic [TIME_W-1:0]  req_task_time     = '0;
   logic               rsp_ready         = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_out_valid;
   logic [ID_W-1:0]    rsp_out_id;
   logic [PRIO_W-1:0]  rsp_out_priority;
   logic [TIME_W-1:0]  rsp_out_time;
   logic [1:0]         rsp_status;
   logic [COUNT_W-1:0] rsp_occupancy;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int mismatch_count;
   int results_owed;

   always #5 clock = ~clock;

   task_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_task_time     (req_task_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_out_time      (rsp_out_time),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy)
   );

   tpq_result_check result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_task_time     (req_task_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_out_time      (rsp_out_time),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .mismatch_count    (mismatch_count),
      .results_owed      (results_owed)
   );

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Drive result ready: random stalls, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
                            input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] dur);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_task_id       <= id;
      req_task_priority <= prio;
      req_task_time     <= dur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random request; narrow field values half the time to force rank ties
   task automatic send_random(input int insert_pct);
      logic              kind;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] dur;
      kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_EXTRACT;
      id   = ID_W'($urandom);
      prio = PRIO_W'($urandom);
      dur  = TIME_W'($urandom);
      if ($urandom_range(1) == 1) id   = ID_W'($urandom_range(7));
      if ($urandom_range(1) == 1) prio = PRIO_W'($urandom_range(3));
      if ($urandom_range(1) == 1) dur  = TIME_W'($urandom_range(3));
      send_item(kind, id, prio, dur);
   endtask

   // Pause the sender until every owed result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
   endtask

   // One idling and stall setting, with an optional long hold: fill past capacity, mixed traffic, drain past empty
   task automatic run_phase(input int idle_pct, input int stall, input logic long_hold);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      repeat (70) send_random(100);
      if (long_hold) begin
         hold_requests++;
         repeat (20) send_random(60);
      end
      repeat (45) send_random(20);
      repeat (45) send_random(50);
      repeat (45) send_random(80);
      repeat (45) send_random(65);
      repeat (70) send_random(0);
      wait_drained();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty extract, field extremes, every tie-break, equal task
      send_item(REQ_EXTRACT, '0, '0, '0);
      send_item(REQ_INSERT, 15'h7FFF, 8'h00, 16'hFFFF);
      send_item(REQ_INSERT, 15'h0000, 8'hFF, 16'h0000);
      send_item(REQ_INSERT, 15'd5, 8'd100, 16'd50);
      send_item(REQ_INSERT, 15'd6, 8'd100, 16'd40);
      send_item(REQ_INSERT, 15'd4, 8'd100, 16'd40);
      send_item(REQ_INSERT, 15'd4, 8'd100, 16'd40);
      send_item(REQ_INSERT, 15'd3, 8'd99, 16'd0);
      send_item(REQ_INSERT, 15'd7, 8'd100, 16'd50);
      send_item(REQ_INSERT, 15'h2AAA, 8'hAA, 16'h5555);
      send_item(REQ_INSERT, 15'h5555, 8'h55, 16'hAAAA);
      repeat (11) send_item(REQ_EXTRACT, 15'h7FFF, 8'hFF, 16'hFFFF);
      wait_drained();

      run_phase(0, 0, 1'b1);
      run_phase(81, 0, 1'b0);
      run_phase(0, 81, 1'b0);
      run_phase(31, 31, 1'b1);

      repeat (5) @(negedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/tpq_pkg.sv
rtl/tpq_cell.sv
rtl/task_priority_queue.sv
tb/sv/tpq_result_check.sv
tb/sv/task_priority_queue_tb.sv
